### rtl/itcl_pkg.sv
// shared types and constants for the interval texture color lookup
`timescale 1ns / 1ps

package itcl_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int COORD_BITS_DEF  = 16;
    localparam int COLOR_BITS_DEF  = 24;

    localparam int BOUND_BITS  = 16;
    localparam int PERIOD_BITS = 16;
    localparam int INDEX_BITS  = 4;
    localparam int COUNT_BITS  = 5;
    localparam int CFG_BITS    = 3;
    localparam int OUT_COLOR_BITS = 24;

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_BASE    = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_WRITTEN = 2'd3
    } status_t;

    typedef enum logic [CFG_BITS-1:0] {
        REG_REPEAT_MODE = 3'd0,
        REG_HAS_BASE    = 3'd1,
        REG_BASE_COLOR  = 3'd2,
        REG_ENTRY_COUNT = 3'd3,
        REG_X_PERIOD    = 3'd4,
        REG_Y_PERIOD    = 3'd5
    } cfg_reg_t;

endpackage

### rtl/interval_texture_color_lookup.sv
// top level of the interval texture color lookup
`timescale 1ns / 1ps

// interval texture color lookup
// request channel: req_valid/req_stall carry either a table write
// (operation = write, entry fields) or a lookup (operation = lookup,
// coord_x/coord_y). every request yields exactly one response on
// rsp_valid/rsp_stall with pixel_color and status, in request order.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write it only while no request is in flight.
// the response passes through the bit-per-stage remainder pipeline of
// each axis, then a range compare stage and a priority select stage.
// throughput is one request per cycle while no response is stalled.
// reset clears all valid bits and the config registers (has_base resets
// to one); table entries are undefined until written.
// when the receiver stalls a held response, the whole pipeline freezes
// and req_stall is raised until the response is taken.
module interval_texture_color_lookup
    import itcl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int COLOR_BITS  = COLOR_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         operation,
    input  logic [INDEX_BITS-1:0]        entry_index,
    input  logic                         x_enabled,
    input  logic                         y_enabled,
    input  logic [BOUND_BITS-1:0]        x_low,
    input  logic [BOUND_BITS-1:0]        x_high,
    input  logic [BOUND_BITS-1:0]        y_low,
    input  logic [BOUND_BITS-1:0]        y_high,
    input  logic [COLOR_BITS-1:0]        entry_color,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [COLOR_BITS-1:0]        pixel_color,
    output logic [1:0]                   status,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_BITS-1:0]          cfg_index,
    input  logic [31:0]                  cfg_data
);

    localparam int MAP_W = (COORD_BITS > PERIOD_BITS) ? COORD_BITS : PERIOD_BITS;
    localparam int LAT   = COORD_BITS + 2;

    typedef struct packed {
        logic                  op;
        logic [INDEX_BITS-1:0] idx;
        logic                  xen;
        logic                  yen;
        logic [BOUND_BITS-1:0] xl;
        logic [BOUND_BITS-1:0] xh;
        logic [BOUND_BITS-1:0] yl;
        logic [BOUND_BITS-1:0] yh;
        logic [COLOR_BITS-1:0] color;
    } req_t;

    logic                   repeat_mode_reg;
    logic                   has_base_reg;
    logic [COLOR_BITS-1:0]  base_color_reg;
    logic [COUNT_BITS-1:0]  entry_count_reg;
    logic [PERIOD_BITS-1:0] x_period_reg;
    logic [PERIOD_BITS-1:0] y_period_reg;

    logic                   adv;
    logic                   vld_reg [LAT];
    req_t                   pay_reg [LAT];
    req_t                   tail;

    logic [MAP_W-1:0]       map_x;
    logic [MAP_W-1:0]       map_y;

    logic [1:0]             flags_reg [TABLE_DEPTH];
    logic [BOUND_BITS-1:0]  xl_reg    [TABLE_DEPTH];
    logic [BOUND_BITS-1:0]  xh_reg    [TABLE_DEPTH];
    logic [BOUND_BITS-1:0]  yl_reg    [TABLE_DEPTH];
    logic [BOUND_BITS-1:0]  yh_reg    [TABLE_DEPTH];
    logic [COLOR_BITS-1:0]  color_reg [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] hit_next;
    logic [TABLE_DEPTH-1:0] hit_reg;
    logic                   hit_valid_reg;
    logic                   hit_op_reg;

    logic                   out_valid_reg;
    logic [COLOR_BITS-1:0]  out_color_reg;
    logic [COLOR_BITS-1:0]  out_color_next;
    status_t                out_status_reg;
    status_t                out_status_next;

    assign adv       = !out_valid_reg || !rsp_stall;
    assign req_stall = !adv;
    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_mode_reg <= 1'b0;
            has_base_reg    <= 1'b1;
            base_color_reg  <= '0;
            entry_count_reg <= '0;
            x_period_reg    <= '0;
            y_period_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_REPEAT_MODE: repeat_mode_reg <= cfg_data[0];
                REG_HAS_BASE:    has_base_reg    <= cfg_data[0];
                REG_BASE_COLOR:  base_color_reg  <= COLOR_BITS'(cfg_data[OUT_COLOR_BITS-1:0]);
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[COUNT_BITS-1:0];
                REG_X_PERIOD:    x_period_reg    <= cfg_data[PERIOD_BITS-1:0];
                REG_Y_PERIOD:    y_period_reg    <= cfg_data[PERIOD_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // request control pipe alongside the mapping pipes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= req_valid;
            for (int s = 1; s < LAT; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg[0] <= '{op: operation, idx: entry_index, xen: x_enabled,
                            yen: y_enabled, xl: x_low, xh: x_high, yl: y_low,
                            yh: y_high, color: entry_color};
            for (int s = 1; s < LAT; s++)
                pay_reg[s] <= pay_reg[s-1];
        end
    end

    assign tail = pay_reg[LAT-1];

    itcl_wrap #(.COORD_BITS(COORD_BITS)) u_wrap_x (
        .clk         (clk),
        .en          (adv),
        .coord       (coord_x),
        .period      (x_period_reg),
        .repeat_mode (repeat_mode_reg),
        .mapped      (map_x)
    );

    itcl_wrap #(.COORD_BITS(COORD_BITS)) u_wrap_y (
        .clk         (clk),
        .en          (adv),
        .coord       (coord_y),
        .period      (y_period_reg),
        .repeat_mode (repeat_mode_reg),
        .mapped      (map_y)
    );

    // table write lands at the same edge lookups sample the table
    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[LAT-1] && tail.op == OP_WRITE)
        begin
            for (int e = 0; e < TABLE_DEPTH; e++)
            begin
                if (32'(tail.idx) == e)
                begin
                    flags_reg[e] <= {tail.yen, tail.xen};
                    xl_reg[e]    <= tail.xl;
                    xh_reg[e]    <= tail.xh;
                    yl_reg[e]    <= tail.yl;
                    yh_reg[e]    <= tail.yh;
                    color_reg[e] <= tail.color;
                end
            end
        end
    end

    // range compare per entry
    always_comb
    begin
        for (int e = 0; e < TABLE_DEPTH; e++)
        begin
            hit_next[e] = (32'(entry_count_reg) > e)
                && (!flags_reg[e][0]
                    || (map_x >= MAP_W'(xl_reg[e]) && map_x <= MAP_W'(xh_reg[e])))
                && (!flags_reg[e][1]
                    || (map_y >= MAP_W'(yl_reg[e]) && map_y <= MAP_W'(yh_reg[e])));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_valid_reg <= 1'b0;
        else if (adv)
            hit_valid_reg <= vld_reg[LAT-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg    <= hit_next;
            hit_op_reg <= tail.op;
        end
    end

    // first hit in table order, else base color or no match; writes report written
    always_comb
    begin
        if (hit_op_reg == OP_WRITE)
        begin
            out_color_next  = '0;
            out_status_next = ST_WRITTEN;
        end
        else if (has_base_reg)
        begin
            out_color_next  = base_color_reg;
            out_status_next = ST_BASE;
        end
        else
        begin
            out_color_next  = '0;
            out_status_next = ST_NOMATCH;
        end
        if (hit_op_reg == OP_LOOKUP)
        begin
            for (int e = TABLE_DEPTH - 1; e >= 0; e--)
            begin
                if (hit_reg[e])
                begin
                    out_color_next  = color_reg[e];
                    out_status_next = ST_MATCH;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= hit_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_color_reg  <= out_color_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign pixel_color = out_color_reg;
    assign status      = out_status_reg;

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (out_valid_reg && rsp_stall))
        else $error("request stalled without a blocked response");

    a_write_color_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_WRITTEN) |-> pixel_color == '0)
        else $error("write response carries a color");

    a_nomatch_needs_no_base: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_NOMATCH) |-> (!has_base_reg && pixel_color == '0))
        else $error("no-match reported while a base color exists");

    a_hit_pipe_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && hit_valid_reg) |=> out_valid_reg)
        else $error("response lost between select and output");

endmodule

### rtl/itcl_wrap.sv
// pipelined coordinate mapping: floor modulo by period or clamp of negatives
`timescale 1ns / 1ps

module itcl_wrap
    import itcl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int MAP_W = (COORD_BITS > PERIOD_BITS) ? COORD_BITS : PERIOD_BITS
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] coord,
    input  logic [PERIOD_BITS-1:0]       period,
    input  logic                         repeat_mode,
    output logic [MAP_W-1:0]             mapped
);

    logic [COORD_BITS-1:0]  mag_reg [COORD_BITS+1];
    logic [COORD_BITS-1:0]  raw_reg [COORD_BITS+1];
    logic                   neg_reg [COORD_BITS+1];
    logic [PERIOD_BITS-1:0] rem_reg [COORD_BITS+1];
    logic [MAP_W-1:0]       mapped_reg;
    logic [MAP_W-1:0]       mapped_next;
    logic [PERIOD_BITS-1:0] rem_fin;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= coord[COORD_BITS-1] ? $unsigned(-coord) : $unsigned(coord);
            raw_reg[0] <= $unsigned(coord);
            neg_reg[0] <= coord[COORD_BITS-1];
            rem_reg[0] <= '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= COORD_BITS; k++)
    begin : g_step
        logic [PERIOD_BITS:0]   trial;
        logic [PERIOD_BITS-1:0] rem_next;

        always_comb
        begin
            trial = {rem_reg[k-1], mag_reg[k-1][COORD_BITS-k]};
            if (trial >= {1'b0, period})
                rem_next = PERIOD_BITS'(trial - {1'b0, period});
            else
                rem_next = trial[PERIOD_BITS-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[k] <= mag_reg[k-1];
                raw_reg[k] <= raw_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                rem_reg[k] <= rem_next;
            end
        end
    end

    assign rem_fin = rem_reg[COORD_BITS];

    always_comb
    begin
        if (repeat_mode)
        begin
            if (period == '0)
                mapped_next = MAP_W'(raw_reg[COORD_BITS]);
            else if (neg_reg[COORD_BITS] && rem_fin != '0)
                mapped_next = MAP_W'(period - rem_fin);
            else
                mapped_next = MAP_W'(rem_fin);
        end
        else if (neg_reg[COORD_BITS])
            mapped_next = '0;
        else
            mapped_next = MAP_W'(raw_reg[COORD_BITS]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mapped_reg <= mapped_next;
    end

    assign mapped = mapped_reg;

endmodule
